// File: rtl/core/orb_pkg.sv
// Shared types, constants and pointer helper for the overwriting ring buffer.
// Used by orb_ctrl, orb_datapath and overwriting_ring_buffer; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package orb_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int CFG_W      = 5;
	localparam int FUNC_W     = 2;

	localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd2;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} cmd_t;

	function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
		input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] n;
		n = CNT_W'(idx) + CNT_W'(1);
		return (n >= cap) ? '0 : n[IDX_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/orb_ctrl.sv
// Sequencing state machine for the overwriting ring buffer.
// Depends on orb_pkg; issues capture and execute commands to orb_datapath.
`timescale 1ns / 1ps
`default_nettype none

module orb_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  wire             out_stall,
	output orb_pkg::cmd_t   cmd
);

	orb_pkg::state_t state_q;
	orb_pkg::state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			orb_pkg::ST_IDLE: if (in_valid) state_nxt = orb_pkg::ST_EXEC;
			orb_pkg::ST_EXEC: state_nxt = orb_pkg::ST_DONE;
			orb_pkg::ST_DONE: if (!out_stall) state_nxt = orb_pkg::ST_IDLE;
			default:          state_nxt = orb_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= orb_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_stall    = (state_q != orb_pkg::ST_IDLE);
	assign out_valid   = (state_q == orb_pkg::ST_DONE);
	assign cmd.capture = (state_q == orb_pkg::ST_IDLE) && in_valid;
	assign cmd.execute = (state_q == orb_pkg::ST_EXEC);

endmodule

`default_nettype wire

// File: rtl/core/orb_datapath.sv
// Storage, pointers, count, capacity register and result registers.
// Depends on orb_pkg; driven by commands from orb_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module orb_datapath (
	input  wire                              clk,
	input  wire                              arst_n,
	input  orb_pkg::cmd_t                    cmd,
	input  wire                              cfg_we,
	input  wire  [orb_pkg::CFG_W-1:0]        cfg_wdata,
	input  wire  [orb_pkg::FUNC_W-1:0]       func,
	input  wire  [orb_pkg::DATA_WIDTH-1:0]   push_value,
	output logic [orb_pkg::DATA_WIDTH-1:0]   read_value,
	output logic                             status,
	output logic [orb_pkg::CNT_W-1:0]        entry_count,
	output logic                             is_full,
	output logic                             is_empty
);

	logic [orb_pkg::DATA_WIDTH-1:0] mem [orb_pkg::DEPTH];

	logic [orb_pkg::FUNC_W-1:0]     func_q;
	logic [orb_pkg::DATA_WIDTH-1:0] wdata_q;
	logic [orb_pkg::DATA_WIDTH-1:0] rdata_q;
	logic                           rd_ok_q;
	logic                           err_q;
	logic [orb_pkg::IDX_W-1:0]      head_q;
	logic [orb_pkg::IDX_W-1:0]      tail_q;
	logic [orb_pkg::CNT_W-1:0]      count_q;
	logic [orb_pkg::CFG_W-1:0]      cap_q;
	logic [orb_pkg::CNT_W-1:0]      eff_cap;
	logic                           do_push;
	logic                           do_read;
	logic                           empty_now;

	always_comb begin
		priority if (cap_q == '0) begin
			eff_cap = orb_pkg::CNT_W'(1);
		end else if (orb_pkg::CNT_W'(cap_q) > orb_pkg::CNT_W'(orb_pkg::DEPTH)) begin
			eff_cap = orb_pkg::CNT_W'(orb_pkg::DEPTH);
		end else begin
			eff_cap = orb_pkg::CNT_W'(cap_q);
		end
	end

	assign empty_now = (count_q == '0);
	assign do_push   = cmd.execute && (func_q == orb_pkg::FUNC_PUSH);
	assign do_read   = (func_q == orb_pkg::FUNC_POP) || (func_q == orb_pkg::FUNC_PEEK);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q  <= func;
			wdata_q <= push_value;
		end
		if (do_push) begin
			mem[tail_q] <= wdata_q;
		end
		if (cmd.execute) begin
			rdata_q <= mem[head_q];
			rd_ok_q <= do_read && !empty_now;
			err_q   <= do_read && empty_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= orb_pkg::CFG_W'(16);
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			cap_q   <= cfg_wdata;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.execute) begin
			unique case (func_q)
				orb_pkg::FUNC_PUSH: begin
					tail_q <= orb_pkg::advance(tail_q, eff_cap);
					if (count_q < eff_cap) begin
						count_q <= count_q + orb_pkg::CNT_W'(1);
					end else begin
						head_q <= orb_pkg::advance(head_q, eff_cap);
					end
				end
				orb_pkg::FUNC_POP: begin
					if (!empty_now) begin
						head_q  <= orb_pkg::advance(head_q, eff_cap);
						count_q <= count_q - orb_pkg::CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign read_value  = rd_ok_q ? rdata_q : '0;
	assign status      = err_q ? orb_pkg::STATUS_EMPTY : orb_pkg::STATUS_OK;
	assign entry_count = count_q;
	assign is_full     = (count_q == eff_cap);
	assign is_empty    = empty_now;

endmodule

`default_nettype wire

// File: rtl/core/overwriting_ring_buffer.sv
// Top level of the overwriting ring buffer: controller plus datapath.
// Depends on orb_pkg, orb_ctrl and orb_datapath.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one operation per beat:
//   func selects push, pop or peek; push_value is the word to store.
//   Output channel (out_valid / out_stall) returns one result beat per
//   operation: read_value, status, entry_count, is_full, is_empty.
//   cfg_we / cfg_wdata write capacity_in_use and empty the buffer; write
//   only while no operation is in flight.
// Timing:
//   An operation is taken in ST_IDLE, executed in the next cycle (a memory
//   write at the tail for a push, one registered read at the head, pointer
//   update for a push or pop), and its result is offered from the cycle after.
//   The three-state controller handles one operation at a time and takes no
//   new one until its result has been accepted without output stall.
// Reset:
//   arst_n clears pointers and count and sets capacity_in_use to 16.
//   Storage is not cleared; only written entries ever reach read_value.
// Stall:
//   While out_stall is high the result holds and in_stall stays high.
`timescale 1ns / 1ps
`default_nettype none

module overwriting_ring_buffer (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire  [orb_pkg::FUNC_W-1:0]       func,
	input  wire  [orb_pkg::DATA_WIDTH-1:0]   push_value,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [orb_pkg::DATA_WIDTH-1:0]   read_value,
	output logic                             status,
	output logic [orb_pkg::CNT_W-1:0]        entry_count,
	output logic                             is_full,
	output logic                             is_empty,
	input  wire                              cfg_we,
	input  wire  [orb_pkg::CFG_W-1:0]        cfg_wdata
);

	orb_pkg::cmd_t cmd;

	orb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	orb_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.func        (func),
		.push_value  (push_value),
		.read_value  (read_value),
		.status      (status),
		.entry_count (entry_count),
		.is_full     (is_full),
		.is_empty    (is_empty)
	);

	a_accept_not_during_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !out_valid)
		else $error("input beat accepted while a result is pending");

	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (in_stall && !out_valid))
		else $error("block not busy after accepting an input beat");

	a_full_empty_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_full && is_empty))
		else $error("result reports full and empty at once");

	a_error_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (is_empty && read_value == '0))
		else $error("empty error with nonempty buffer or nonzero data");

endmodule

`default_nettype wire
